FILE: design/rapid_fire_trigger_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the trigger controller core.
// ----------------------------------------------------------------------------
`ifndef RAPID_FIRE_TRIGGER_CONTROLLER_CORE_ASSERT_SVH
`define RAPID_FIRE_TRIGGER_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RFTC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rftc assertion failed");

// Next-cycle implication, checked out of reset.
`define RFTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rftc assertion failed");

`endif

FILE: design/rftc_pkg.sv
// ----------------------------------------------------------------------------
// rftc_pkg
// Types, codes and reset constants of the rapid fire trigger controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rftc_pkg;

    localparam int ADC_W    = 10;
    localparam int BASE_W   = 17;
    localparam int PULSE_W  = 16;
    localparam int CNT_W    = 8;
    localparam int SPEED_W  = 12;
    localparam int DIVSR_W  = SPEED_W - 1;
    localparam int PADDR_W  = 4;

    // event kinds
    localparam logic [1:0] OP_BUTTON  = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_ADC     = 2'd2;

    // speed entry phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TENS = 2'd1;
    localparam logic [1:0] PH_ONES = 2'd2;

    // register indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_BASE      = 2'd1;
    localparam logic [1:0] REG_PULSE     = 2'd2;
    localparam logic [1:0] REG_MIN_SPEED = 2'd3;

    // reset values
    localparam logic [ADC_W-1:0]   THRESHOLD_RST = 10'h070;
    localparam logic [BASE_W-1:0]  BASE_RST      = 17'd125000;
    localparam logic [PULSE_W-1:0] PULSE_RST     = 16'd2000;
    localparam logic [CNT_W-1:0]   MIN_SPEED_RST = 8'd4;
    localparam logic [SPEED_W-1:0] SPEED_RST     = 12'd40;

    localparam logic [CNT_W-1:0]   COUNT_MAX  = 8'hFF;
    localparam logic [15:0]        PERIOD_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]       opcode;
        logic             trigger_pulled;
        logic [ADC_W-1:0] adc_sample;
    } rftc_in_t;

    typedef struct packed {
        logic             led_on;
        logic             pwm_running;
        logic [15:0]      pwm_period;
        logic [15:0]      pwm_compare;
        logic [CNT_W-1:0] blink_count;
        logic             ready_blink;
        logic [1:0]       entry_phase;
    } rftc_out_t;

endpackage

`default_nettype wire

FILE: design/rapid_fire_trigger_controller_core.sv
// ----------------------------------------------------------------------------
// rapid_fire_trigger_controller_core
// Speed entry, PWM programming and release detection for a rapid fire mod.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------
//  s_*       | in        | s_valid / s_ready     | rftc_in_t  (event)
//  m_*       | out       | m_valid / m_ready     | rftc_out_t (status)
//  APB       | in        | psel/penable/pready   | 4 config registers
//
//  Every transaction yields one status transaction.
//  Trigger pull while enabled with speed of 2 or more passes through DIV;
//  the period comes from a restoring divider, one quotient bit per cycle,
//  for 17 bits. Every other event: accept, then report.
//  s_ready is high only in IDLE; the output register holds a result until
//  m_ready, and the sequencer waits in REPORT while it is full.
//  aresetn is synchronous; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rapid_fire_trigger_controller_core_assert.svh"

module rapid_fire_trigger_controller_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // event channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire rftc_pkg::rftc_in_t               s_data,
    // status channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output rftc_pkg::rftc_out_t                   m_data,
    // config port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rftc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_REPORT = 3'b100
    } state_t;

    localparam int STEP_W = $clog2(rftc_pkg::BASE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(rftc_pkg::BASE_W - 1);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [rftc_pkg::ADC_W-1:0]   threshold_reg;
    logic [rftc_pkg::BASE_W-1:0]  base_reg;
    logic [rftc_pkg::PULSE_W-1:0] pulse_reg;
    logic [rftc_pkg::CNT_W-1:0]   min_speed_reg;

    logic                         cfg_wr;
    logic [1:0]                   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= rftc_pkg::THRESHOLD_RST;
            base_reg      <= rftc_pkg::BASE_RST;
            pulse_reg     <= rftc_pkg::PULSE_RST;
            min_speed_reg <= rftc_pkg::MIN_SPEED_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rftc_pkg::REG_THRESHOLD: threshold_reg <= pwdata[rftc_pkg::ADC_W-1:0];
                rftc_pkg::REG_BASE:      base_reg      <= pwdata[rftc_pkg::BASE_W-1:0];
                rftc_pkg::REG_PULSE:     pulse_reg     <= pwdata[rftc_pkg::PULSE_W-1:0];
                rftc_pkg::REG_MIN_SPEED: min_speed_reg <= pwdata[rftc_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rftc_pkg::REG_THRESHOLD: prdata = 32'(threshold_reg);
            rftc_pkg::REG_BASE:      prdata = 32'(base_reg);
            rftc_pkg::REG_PULSE:     prdata = 32'(pulse_reg);
            rftc_pkg::REG_MIN_SPEED: prdata = 32'(min_speed_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // controller state
    // ------------------------------------------------------------------
    state_t                       state_reg, state_next;
    logic                         enabled_reg, enabled_next;
    logic                         shooting_reg, shooting_next;
    logic                         pwm_on_reg, pwm_on_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [rftc_pkg::CNT_W-1:0]   tens_reg, tens_next;
    logic [rftc_pkg::CNT_W-1:0]   ones_reg, ones_next;
    logic [rftc_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [15:0]                  period_reg, period_next;
    logic [15:0]                  compare_reg, compare_next;
    logic [rftc_pkg::CNT_W-1:0]   blink_reg, blink_next;
    logic                         rdy_reg, rdy_next;

    // divider datapath
    logic [rftc_pkg::DIVSR_W-1:0] divsr_reg, divsr_next;
    logic [rftc_pkg::DIVSR_W-1:0] rem_reg, rem_next;
    logic [rftc_pkg::BASE_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0]            step_reg, step_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    rftc_pkg::rftc_out_t          m_data_reg, m_data_next;

    logic                         accept;
    logic [rftc_pkg::DIVSR_W:0]   trial;
    logic                         trial_ge;
    logic [rftc_pkg::DIVSR_W:0]   trial_diff;
    logic [rftc_pkg::BASE_W-1:0]  quo_final;
    logic [15:0]                  quo_sat;
    logic [rftc_pkg::SPEED_W-1:0] entered_speed;
    logic [rftc_pkg::DIVSR_W-1:0] half_speed;
    logic                         out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // one restoring step: shift in the next dividend bit, try a subtract
    assign trial      = {rem_reg, quo_reg[rftc_pkg::BASE_W-1]};
    assign trial_ge   = (trial >= {1'b0, divsr_reg});
    assign trial_diff = trial - {1'b0, divsr_reg};
    assign quo_final  = {quo_reg[rftc_pkg::BASE_W-2:0], trial_ge};
    assign quo_sat    = quo_final[rftc_pkg::BASE_W-1] ? rftc_pkg::PERIOD_MAX
                                                      : quo_final[15:0];

    // tens*10 + ones; at most 2805, fits the speed width
    assign entered_speed = {1'b0, tens_reg, 3'b000} + {3'b000, tens_reg, 1'b0}
                         + {4'b0000, ones_reg};
    assign half_speed    = speed_reg[rftc_pkg::SPEED_W-1:1];

    always_comb begin
        state_next    = state_reg;
        enabled_next  = enabled_reg;
        shooting_next = shooting_reg;
        pwm_on_next   = pwm_on_reg;
        phase_next    = phase_reg;
        tens_next     = tens_reg;
        ones_next     = ones_reg;
        speed_next    = speed_reg;
        period_next   = period_reg;
        compare_next  = compare_reg;
        blink_next    = blink_reg;
        rdy_next      = rdy_reg;
        divsr_next    = divsr_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    blink_next = '0;
                    rdy_next   = 1'b0;
                    state_next = ST_REPORT;
                    priority if (s_data.opcode == rftc_pkg::OP_BUTTON) begin
                        priority if (enabled_reg) begin
                            pwm_on_next  = 1'b0;
                            enabled_next = 1'b0;
                        end else if (phase_reg == rftc_pkg::PH_IDLE
                                     && s_data.trigger_pulled) begin
                            phase_next = rftc_pkg::PH_TENS;
                            rdy_next   = 1'b1;
                        end else if (phase_reg == rftc_pkg::PH_TENS) begin
                            phase_next = rftc_pkg::PH_ONES;
                            blink_next = tens_reg;
                            rdy_next   = 1'b1;
                        end else if (phase_reg == rftc_pkg::PH_ONES) begin
                            blink_next   = ones_reg;
                            speed_next   = (entered_speed < {4'b0000, min_speed_reg})
                                         ? {4'b0000, min_speed_reg} : entered_speed;
                            tens_next    = '0;
                            ones_next    = '0;
                            phase_next   = rftc_pkg::PH_IDLE;
                            enabled_next = 1'b1;
                        end else begin
                            phase_next   = rftc_pkg::PH_IDLE;
                            enabled_next = 1'b1;
                        end
                    end else if (s_data.opcode == rftc_pkg::OP_TRIGGER) begin
                        if (s_data.trigger_pulled && !shooting_reg) begin
                            priority if (enabled_reg) begin
                                shooting_next = 1'b1;
                                pwm_on_next   = 1'b1;
                                if (half_speed == '0) begin
                                    // speed 0 or 1: no divide, period pegged
                                    period_next  = rftc_pkg::PERIOD_MAX;
                                    compare_next = speed_reg[0]
                                                 ? (rftc_pkg::PERIOD_MAX >> 1) : pulse_reg;
                                end else begin
                                    divsr_next = half_speed;
                                    rem_next   = '0;
                                    quo_next   = base_reg;
                                    step_next  = '0;
                                    state_next = ST_DIV;
                                end
                            end else if (phase_reg == rftc_pkg::PH_TENS) begin
                                if (tens_reg != rftc_pkg::COUNT_MAX)
                                    tens_next = tens_reg + 1'b1;
                            end else if (phase_reg == rftc_pkg::PH_ONES) begin
                                if (ones_reg != rftc_pkg::COUNT_MAX)
                                    ones_next = ones_reg + 1'b1;
                            end else begin
                            end
                        end
                    end else if (s_data.opcode == rftc_pkg::OP_ADC) begin
                        if (shooting_reg && s_data.adc_sample < threshold_reg) begin
                            shooting_next = 1'b0;
                            pwm_on_next   = 1'b0;
                        end
                    end else begin
                        // unused opcode: status only
                    end
                end
            end

            ST_DIV: begin
                rem_next  = trial_ge ? trial_diff[rftc_pkg::DIVSR_W-1:0]
                                     : trial[rftc_pkg::DIVSR_W-1:0];
                quo_next  = quo_final;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    period_next  = quo_sat;
                    compare_next = speed_reg[0] ? (quo_sat >> 1) : pulse_reg;
                    state_next   = ST_REPORT;
                end
            end

            ST_REPORT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.led_on      = enabled_reg;
                    m_data_next.pwm_running = pwm_on_reg;
                    m_data_next.pwm_period  = period_reg;
                    m_data_next.pwm_compare = compare_reg;
                    m_data_next.blink_count = blink_reg;
                    m_data_next.ready_blink = rdy_reg;
                    m_data_next.entry_phase = phase_reg;
                    state_next              = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            enabled_reg  <= 1'b0;
            shooting_reg <= 1'b0;
            pwm_on_reg   <= 1'b0;
            phase_reg    <= rftc_pkg::PH_IDLE;
            tens_reg     <= '0;
            ones_reg     <= '0;
            speed_reg    <= rftc_pkg::SPEED_RST;
            period_reg   <= '0;
            compare_reg  <= '0;
            blink_reg    <= '0;
            rdy_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            enabled_reg  <= enabled_next;
            shooting_reg <= shooting_next;
            pwm_on_reg   <= pwm_on_next;
            phase_reg    <= phase_next;
            tens_reg     <= tens_next;
            ones_reg     <= ones_next;
            speed_reg    <= speed_next;
            period_reg   <= period_next;
            compare_reg  <= compare_next;
            blink_reg    <= blink_next;
            rdy_reg      <= rdy_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        divsr_reg  <= divsr_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RFTC_ASSERT_NEXT(a_div_ends, aclk, aresetn,
        (state_reg == ST_DIV && step_reg == LAST_STEP), (state_reg == ST_REPORT))
    `RFTC_ASSERT_NOW(a_rem_below_divsr, aclk, aresetn,
        (state_reg == ST_DIV), (rem_reg < divsr_reg))
    `RFTC_ASSERT_NOW(a_pwm_needs_shooting, aclk, aresetn,
        pwm_on_reg, shooting_reg)
    `RFTC_ASSERT_NOW(a_enabled_phase_idle, aclk, aresetn,
        enabled_reg, (phase_reg == rftc_pkg::PH_IDLE))

endmodule

`default_nettype wire
